/* rtl/core/utf8_validating_decoder_macros.svh */
// Assertion macros for the UTF-8 validating decoder.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef UTF8_VALIDATING_DECODER_MACROS_SVH
`define UTF8_VALIDATING_DECODER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define U8VD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define U8VD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/u8vd_pkg.sv */
// Shared types and constants of the UTF-8 validating decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package u8vd_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [20:0] MAX_SCALAR   = 21'h10FFFF;
  localparam logic [20:0] SURR_LO      = 21'h00D800;
  localparam logic [20:0] SURR_HI      = 21'h00DFFF;
  localparam logic [7:0]  CONT_MASK    = 8'hC0;
  localparam logic [7:0]  CONT_TAG     = 8'h80;
  localparam logic [5:0]  PAYLOAD_MASK = 6'h3F;
  localparam logic [7:0]  CTRL_LIMIT   = 8'h20;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_INVALID = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  // What kind of result a slot describes.
  typedef enum logic [1:0] {
    SLOT_ASCII = 2'd0,  // single-byte character
    SLOT_CLOSE = 2'd1,  // pending char closed by a new non-continuation byte
    SLOT_END   = 2'd2   // pending char closed by end of text
  } slot_kind_t;

  // Snapshot of one character to be finished by the back end.
  typedef struct packed {
    slot_kind_t  kind;
    logic [20:0] value;
    logic [2:0]  seen;
    logic [2:0]  expected;
    logic [4:0]  pbc;
    logic        lead_bad;
  } slot_t;

  // One queue entry: everything one input byte causes (1 or 2 results).
  typedef struct packed {
    logic [1:0]      cnt;
    slot_t [1:0]     slot;
  } rec_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } qstat_t;

  function automatic slot_t make_slot(slot_kind_t kind, logic [20:0] value,
                                      logic [2:0] seen, logic [2:0] expected,
                                      logic [4:0] pbc, logic lead_bad);
    slot_t s;
    s.kind     = kind;
    s.value    = value;
    s.seen     = seen;
    s.expected = expected;
    s.pbc      = pbc;
    s.lead_bad = lead_bad;
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/u8vd_front.sv */
// Front end: accepts text bytes, tracks the pending character and emits
// one queue record per byte that causes results. Uses u8vd_pkg.
`default_nettype none

module u8vd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic [7:0]     text_byte,
  input  wire logic           end_of_text,
  output u8vd_pkg::rec_t      rec,
  output logic                push
);

  logic        pend_r,  pend_nxt;
  logic [2:0]  exp_r,   exp_nxt;
  logic [2:0]  seen_r,  seen_nxt;
  logic [20:0] value_r, value_nxt;
  logic [4:0]  pbc_r,   pbc_nxt;
  logic        lb_r,    lb_nxt;

  logic        is_cont;
  logic [2:0]  seen_inc;
  logic [2:0]  lead_e;
  logic [20:0] lead_val;
  logic [1:0]  cnt;

  assign is_cont  = (text_byte & u8vd_pkg::CONT_MASK) == u8vd_pkg::CONT_TAG;
  assign seen_inc = (seen_r < 3'd7) ? seen_r + 3'd1 : seen_r;

  // Announced length: 1 plus the run of ones after the top bit, capped at 5.
  always_comb begin
    if (!text_byte[6])      lead_e = 3'd1;
    else if (!text_byte[5]) lead_e = 3'd2;
    else if (!text_byte[4]) lead_e = 3'd3;
    else if (!text_byte[3]) lead_e = 3'd4;
    else                    lead_e = 3'd5;
  end

  assign lead_val = {13'd0, text_byte & (8'hFF >> lead_e)};

  always_comb begin
    pend_nxt  = pend_r;
    exp_nxt   = exp_r;
    seen_nxt  = seen_r;
    value_nxt = value_r;
    pbc_nxt   = pbc_r;
    lb_nxt    = lb_r;
    rec       = '0;
    cnt       = 2'd0;
    if (accept) begin
      if (is_cont && pend_r) begin
        seen_nxt = seen_inc;
        if (seen_inc <= 3'd4) begin
          value_nxt = {value_r[14:0], text_byte[5:0] & u8vd_pkg::PAYLOAD_MASK};
          pbc_nxt   = pbc_r + 5'd6;
        end
      end else begin
        if (pend_r) begin
          rec.slot[cnt[0]] = u8vd_pkg::make_slot(u8vd_pkg::SLOT_CLOSE, value_r, seen_r,
                                                 exp_r, pbc_r, lb_r);
          cnt = cnt + 2'd1;
        end
        if (!text_byte[7]) begin
          rec.slot[cnt[0]] = u8vd_pkg::make_slot(u8vd_pkg::SLOT_ASCII,
                                                 {13'd0, text_byte}, 3'd1, 3'd1,
                                                 5'd0, 1'b0);
          cnt       = cnt + 2'd1;
          pend_nxt  = 1'b0;
          exp_nxt   = 3'd0;
          seen_nxt  = 3'd0;
          value_nxt = '0;
          pbc_nxt   = 5'd0;
          lb_nxt    = 1'b0;
        end else begin
          pend_nxt  = 1'b1;
          exp_nxt   = lead_e;
          seen_nxt  = 3'd1;
          value_nxt = lead_val;
          pbc_nxt   = 5'd7 - {2'd0, lead_e};
          lb_nxt    = (lead_e == 3'd1) || (lead_e > 3'd4) ||
                      ((lead_e == 3'd2) && (lead_val <= 21'd1));
        end
      end
      // End of text closes whatever is still open.
      if (end_of_text && pend_nxt) begin
        rec.slot[cnt[0]] = u8vd_pkg::make_slot(u8vd_pkg::SLOT_END, value_nxt, seen_nxt,
                                               exp_nxt, pbc_nxt, lb_nxt);
        cnt       = cnt + 2'd1;
        pend_nxt  = 1'b0;
        exp_nxt   = 3'd0;
        seen_nxt  = 3'd0;
        value_nxt = '0;
        pbc_nxt   = 5'd0;
        lb_nxt    = 1'b0;
      end
    end
    rec.cnt = cnt;
  end

  assign push = accept && (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      exp_r   <= 3'd0;
      seen_r  <= 3'd0;
      value_r <= '0;
      pbc_r   <= 5'd0;
      lb_r    <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      exp_r   <= exp_nxt;
      seen_r  <= seen_nxt;
      value_r <= value_nxt;
      pbc_r   <= pbc_nxt;
      lb_r    <= lb_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/u8vd_queue.sv */
// Short record queue between front and back end of the decoder.
// Uses u8vd_pkg for the record type and depth.
`default_nettype none

module u8vd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire u8vd_pkg::rec_t rec_in,
  input  wire logic           pop,
  output u8vd_pkg::rec_t      rec_out,
  output u8vd_pkg::qstat_t    qstat
);

  u8vd_pkg::rec_t mem_r [u8vd_pkg::QDEPTH];

  logic [u8vd_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [u8vd_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [u8vd_pkg::QCNT_W-1:0] count_r,  count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + u8vd_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + u8vd_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop)      count_nxt = count_r + u8vd_pkg::QCNT_W'(1);
    else if (!push && pop) count_nxt = count_r - u8vd_pkg::QCNT_W'(1);
  end

  assign rec_out         = mem_r[rd_ptr_r];
  assign qstat.not_empty = count_r != '0;
  assign qstat.full      = count_r == u8vd_pkg::QCNT_W'(u8vd_pkg::QDEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= rec_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/u8vd_back.sv */
// Back end: walks the slots of each queued record, grades each character
// and drives the registered result stream. Uses u8vd_pkg.
`default_nettype none

module u8vd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire u8vd_pkg::rec_t   rec,
  input  wire u8vd_pkg::qstat_t qstat,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [20:0]           out_cp,
  output logic [2:0]            out_len,
  output u8vd_pkg::status_t     out_status,
  output logic                  out_last
);

  logic                idx_r, idx_nxt;
  logic                valid_r, valid_nxt;
  logic [20:0]         cp_r;
  logic [2:0]          len_r;
  u8vd_pkg::status_t   st_r, st_cur;
  logic                last_r;

  u8vd_pkg::slot_t     s;
  logic                load;
  logic                is_last;
  logic [4:0]          shamt;
  logic                overlong;
  logic                bad;

  assign s       = rec.slot[idx_r];
  assign is_last = {1'b0, idx_r} == (rec.cnt - 2'd1);
  assign load    = qstat.not_empty && (!valid_r || out_ready);
  assign pop     = load && is_last;

  // Overlong: value fits in five fewer bits than the encoding carried.
  assign shamt    = s.pbc - 5'd5;
  assign overlong = (s.pbc >= 5'd5) && ((s.value >> shamt) == '0);
  assign bad      = s.lead_bad || (s.seen != s.expected) ||
                    (s.value > u8vd_pkg::MAX_SCALAR) ||
                    ((s.value >= u8vd_pkg::SURR_LO) && (s.value <= u8vd_pkg::SURR_HI)) ||
                    overlong;

  always_comb begin
    unique case (s.kind)
      u8vd_pkg::SLOT_ASCII: begin
        st_cur = (s.value[7:0] < u8vd_pkg::CTRL_LIMIT) ? u8vd_pkg::ST_INVALID
                                                        : u8vd_pkg::ST_VALID;
      end
      u8vd_pkg::SLOT_END: begin
        if (!s.lead_bad && (s.seen < s.expected)) st_cur = u8vd_pkg::ST_TRUNC;
        else st_cur = bad ? u8vd_pkg::ST_INVALID : u8vd_pkg::ST_VALID;
      end
      default: begin
        st_cur = bad ? u8vd_pkg::ST_INVALID : u8vd_pkg::ST_VALID;
      end
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = is_last ? 1'b0 : 1'b1;
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r   <= s.value;
      len_r  <= s.seen;
      st_r   <= st_cur;
      last_r <= is_last;
    end
  end

  assign out_valid  = valid_r;
  assign out_cp     = cp_r;
  assign out_len    = len_r;
  assign out_status = st_r;
  assign out_last   = last_r;

endmodule

`default_nettype wire

/* rtl/core/utf8_validating_decoder.sv */
// Top level of the UTF-8 validating decoder: front end, record queue, back end.
// Depends on u8vd_pkg, u8vd_front, u8vd_queue, u8vd_back and the macros header.
`default_nettype none

// UTF-8 validating decoder. Takes one text byte per request on the in_ stream
// (in_tlast marks the last byte of a text) and gives one result per character
// on the out_ stream: code point, byte count (saturating at 7) and status
// (0 valid, 1 invalid, 2 truncated at end of text); out_tlast marks the final
// result caused by one input byte. A byte is accepted every cycle while the
// four-entry record queue has room; a byte causes zero, one or two results,
// and the result register issues one result per cycle while the receiver is
// ready, so the queue absorbs the difference. The first result of a byte
// passes through the record queue and then the result register. A
// continuation byte that completes nothing gives no result until the
// character closes, either on the next non-continuation byte or at end of
// text. Results of one text and the next follow with no gap or flush needed.

`include "utf8_validating_decoder_macros.svh"

module utf8_validating_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [20:0] code_point, [23:21] char_length,
                                       // [25:24] status, [31:26] zero
  output logic             out_tlast   // last_of_run
);

  u8vd_pkg::rec_t    f_rec;
  u8vd_pkg::rec_t    q_rec;
  u8vd_pkg::qstat_t  qstat;
  logic              push;
  logic              pop;
  logic              in_accept;

  logic [20:0]       cp;
  logic [2:0]        len;
  u8vd_pkg::status_t st;

  assign in_tready = !qstat.full;
  assign in_accept = in_tvalid && in_tready;

  u8vd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .text_byte   (in_tdata),
    .end_of_text (in_tlast),
    .rec         (f_rec),
    .push        (push)
  );

  u8vd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .rec_in  (f_rec),
    .pop     (pop),
    .rec_out (q_rec),
    .qstat   (qstat)
  );

  u8vd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec        (q_rec),
    .qstat      (qstat),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_cp     (cp),
    .out_len    (len),
    .out_status (st),
    .out_last   (out_tlast)
  );

  assign out_tdata = {6'd0, st, len, cp};

  // Truncation only comes from the end-of-text close, which is always last.
  `U8VD_ASSERT_IMP(a_trunc_is_last, out_tvalid && (st == u8vd_pkg::ST_TRUNC), out_tlast, "truncated result not marked last")

  // A valid character never exceeds the scalar range.
  `U8VD_ASSERT_IMP(a_valid_in_range, out_tvalid && (st == u8vd_pkg::ST_VALID), cp <= u8vd_pkg::MAX_SCALAR, "valid result out of range")

  // A valid one-byte character is ASCII from 20h up to 7Fh.
  `U8VD_ASSERT_IMP(a_ascii_valid, out_tvalid && (st == u8vd_pkg::ST_VALID) && (len == 3'd1), (cp >= 21'h20) && (cp < 21'h80), "bad one-byte valid result")

  // An accepted ASCII byte always leaves a record in the queue.
  `U8VD_ASSERT_NXT(a_ascii_queued, in_accept && !in_tdata[7], qstat.not_empty, "ASCII byte left no record")

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for the UTF-8 validating decoder: byte stream in, characters out.
// Depends on u8vd_pkg and utf8_validating_decoder; predicts results in-bench.
`timescale 1ns / 1ps

module tb;

  // One expected character as it leaves out_tdata / out_tlast.
  typedef struct packed {
    logic [20:0]       code_point;
    logic [2:0]        char_length;
    u8vd_pkg::status_t status;
    logic              last_of_run;
  } char_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] text_byte
  logic        in_tlast   = 1'b0;   // end_of_text
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;           // [20:0] code_point, [23:21] char_length,
                                    // [25:24] status, [31:26] zero
  logic        out_tlast;           // last_of_run

  // Expected characters, oldest first.
  char_result_t char_q[$];
  // Bytes of the text being assembled for sending.
  logic [7:0]   text_q[$];

  int mismatches    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Decoder state mirror.
  logic        open_char;
  logic [2:0]  want_len;
  logic [2:0]  got_len;
  logic [20:0] gathered;
  logic [4:0]  payload_bits;
  logic        lead_invalid;

  utf8_validating_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_char();
    open_char    = 1'b0;
    want_len     = 3'd0;
    got_len      = 3'd0;
    gathered     = 21'd0;
    payload_bits = 5'd0;
    lead_invalid = 1'b0;
  endfunction

  // Finish the open character; at_end selects the end-of-text rules.
  function automatic void close_open_char(input logic at_end);
    char_result_t r;
    logic         bad;
    r.code_point  = gathered;
    r.char_length = got_len;
    r.last_of_run = 1'b0;
    if (at_end && !lead_invalid && got_len < want_len) begin
      r.status = u8vd_pkg::ST_TRUNC;
    end else begin
      bad = lead_invalid || (got_len != want_len) ||
            (gathered > u8vd_pkg::MAX_SCALAR) ||
            (gathered >= u8vd_pkg::SURR_LO && gathered <= u8vd_pkg::SURR_HI);
      // Overlong: the top five payload bits of the encoding are all zero.
      if (!bad && payload_bits >= 5'd5 && (gathered >> (payload_bits - 5'd5)) == 0)
        bad = 1'b1;
      r.status = bad ? u8vd_pkg::ST_INVALID : u8vd_pkg::ST_VALID;
    end
    char_q.push_back(r);
    clear_char();
  endfunction

  // Work out everything one accepted byte causes.
  function automatic void predict_byte(input logic [7:0] b, input logic eot);
    int           n_prior;
    int           e;
    logic [7:0]   m;
    char_result_t r;
    n_prior = char_q.size();
    if ((b & u8vd_pkg::CONT_MASK) == u8vd_pkg::CONT_TAG && open_char) begin
      if (got_len < 3'd7) got_len = got_len + 3'd1;
      if (got_len <= 3'd4) begin
        gathered     = {gathered[14:0], b[5:0]};
        payload_bits = payload_bits + 5'd6;
      end
    end else begin
      if (open_char) close_open_char(1'b0);
      if (b < 8'h80) begin
        r.code_point  = {13'd0, b};
        r.char_length = 3'd1;
        r.status      = (b < u8vd_pkg::CTRL_LIMIT) ? u8vd_pkg::ST_INVALID
                                                   : u8vd_pkg::ST_VALID;
        r.last_of_run = 1'b0;
        char_q.push_back(r);
      end else begin
        e = 1;
        m = 8'h40;
        while ((b & m) != 0 && e < 5) begin
          e++;
          m = m >> 1;
        end
        open_char    = 1'b1;
        want_len     = e[2:0];
        got_len      = 3'd1;
        gathered     = {13'd0, b & (8'hFF >> e)};
        payload_bits = 5'(7 - e);
        lead_invalid = (e == 1 || e > 4 || (e == 2 && gathered <= 21'd1));
      end
    end
    if (eot && open_char) close_open_char(1'b1);
    if (char_q.size() > n_prior) char_q[char_q.size() - 1].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted requests, check on accepted results.
  // Sampled at the edge, so values are the ones settled before it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    char_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (char_q.size() == 0) begin
          if (mismatches < 10)
            $display("ERROR: result with none expected: tdata=%h tlast=%b",
                     out_tdata, out_tlast);
          mismatches++;
        end else begin
          want = char_q.pop_front();
          if (out_tdata[20:0] !== want.code_point ||
              out_tdata[23:21] !== want.char_length ||
              out_tdata[25:24] !== want.status ||
              out_tdata[31:26] !== 6'd0 ||
              out_tlast !== want.last_of_run) begin
            if (mismatches < 10)
              $display({"ERROR: cp exp %h got %h, len exp %0d got %0d, ",
                        "status exp %0d got %0d, last exp %b got %b, pad %h"},
                       want.code_point, out_tdata[20:0],
                       want.char_length, out_tdata[23:21],
                       want.status, out_tdata[25:24],
                       want.last_of_run, out_tlast, out_tdata[31:26]);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // One byte request, after idle cycles drawn from send_idle_pct; tvalid stays
  // high after acceptance, so it drops between bytes only for those idle cycles.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
  endtask

  // Send text_q, optionally flagging its last byte as end of text.
  task automatic send_text(input logic mark_end);
    for (int i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], mark_end && (i == text_q.size() - 1));
    text_q.delete();
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Standard UTF-8 encoding of cp in n bytes (n may exceed the minimum).
  function automatic void encode_char(input int cp, input int n);
    if (n == 1) begin
      text_q.push_back(8'(cp & 8'h7F));
    end else begin
      text_q.push_back(8'(((8'hFF << (8 - n)) & 8'hFF) |
                          ((cp >> (6 * (n - 1))) & (8'hFF >> (n + 1)))));
      for (int i = n - 2; i >= 0; i--)
        text_q.push_back(8'(u8vd_pkg::CONT_TAG |
                            ((cp >> (6 * i)) & u8vd_pkg::PAYLOAD_MASK)));
    end
  endfunction

  function automatic int random_code_point(input int n);
    case (n)
      1:       return ($urandom_range(19) == 0) ? $urandom_range(8'h1F) :
                                                  $urandom_range(8'h7F, 8'h20);
      2:       return $urandom_range(12'h7FF, 8'h80);
      3:       return $urandom_range(16'hFFFF, 12'h800);
      default: return ($urandom_range(9) == 0) ? $urandom_range(21'h1FFFFF, 21'h110000) :
                                                 $urandom_range(21'h10FFFF, 17'h10000);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    text_q = '{8'h00, 8'h7F};                 // control byte, top of ASCII
    send_text(1'b0);
    text_q = '{8'h80, 8'hBF};                 // stray continuation absorbs the next
    send_text(1'b0);
    text_q = '{8'hC1, 8'hBF};                 // overlong two-byte lead
    send_text(1'b0);
    text_q = '{8'hE2, 8'h82, 8'h41};          // closed early by ASCII: two results
    send_text(1'b0);
    text_q = '{8'hED, 8'hA0, 8'h80};          // surrogate
    send_text(1'b0);
    text_q = '{8'hFF, 8'h80};                 // long lead
    send_text(1'b0);
    text_q = '{8'hC3, 8'hA9, 8'hA9, 8'hA9,    // too many bytes, length saturates
               8'hA9, 8'hA9, 8'hA9, 8'hA9};
    send_text(1'b0);
    text_q = '{8'hE2, 8'h82};                 // truncated at end of text
    send_text(1'b1);
    text_q = '{8'hC0};                        // bad lead at end: invalid, not truncated
    send_text(1'b1);
    text_q = '{8'hF0, 8'h9F, 8'h98, 8'h80};   // complete four-byte char ending the text
    send_text(1'b1);
  endtask

  // Sender goes quiet until the decoder has drained, with and without a
  // character still open inside it.
  task automatic test_drain_pause();
    text_q = '{8'h41};
    send_text(1'b0);
    wait_for_results();
    text_q = '{8'hE2, 8'h82};                 // open char, nothing due yet
    send_text(1'b0);
    wait_for_results();
    text_q = '{8'hAC};
    send_text(1'b1);
    wait_for_results();
  endtask

  // Mostly well-formed characters with random content, the rest malformed.
  task automatic test_random_text(input int n_bytes);
    int   sent;
    int   pick;
    int   n;
    int   cp;
    logic mark_end;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      n    = $urandom_range(4, 1);
      cp   = random_code_point(n);
      if (pick < 68) begin
        encode_char(cp, n);
      end else if (pick < 75) begin           // overlong: small value, long form
        n = $urandom_range(4, 2);
        cp = $urandom_range((n == 2) ? 8'h7F : (n == 3) ? 12'h7FF : 16'hFFFF);
        encode_char(cp, n);
      end else if (pick < 82) begin           // missing continuation bytes
        n = $urandom_range(4, 2);
        encode_char(random_code_point(n), n);
        repeat ($urandom_range(n - 1, 1)) void'(text_q.pop_back());
      end else if (pick < 88) begin           // surplus continuation bytes
        encode_char(cp, n);
        repeat ($urandom_range(4, 1))
          text_q.push_back(8'(u8vd_pkg::CONT_TAG |
                              $urandom_range(u8vd_pkg::PAYLOAD_MASK)));
      end else if (pick < 94) begin           // any byte at all
        text_q.push_back(8'($urandom_range(255)));
      end else begin                          // run of high bytes: long leads, strays
        repeat ($urandom_range(3, 1)) text_q.push_back(8'($urandom_range(255, 128)));
      end
      mark_end = ($urandom_range(9) == 0);
      sent += text_q.size();
      send_text(mark_end);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_char();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();

    test_random_text(190);                    // full rate both sides

    send_idle_pct = 61;
    test_random_text(90);
    test_drain_pause();
    test_random_text(100);

    send_idle_pct = 0;
    stall_pct     = 61;
    test_random_text(190);

    send_idle_pct = 22;
    stall_pct     = 22;
    test_random_text(190);

    // Let the tail drain, then a few quiet cycles to catch strays.
    in_tvalid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
